/* hw/rtl/spq_pkg.sv */
// spq_pkg: constants, status codes and the per-cell operation word
// for the sorted priority queue; no dependencies
package spq_pkg;

    // queue geometry
    localparam int DEPTH   = 64;
    localparam int COUNT_W = $clog2(DEPTH + 1);
    localparam int VAL_W   = 32;
    localparam int PRI_W   = 15;
    localparam int REQ_W   = 16;
    localparam int ST_W    = 2;

    // command codes
    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    // status codes
    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL    = 2'd1;
    localparam logic [ST_W-1:0] ST_BADPRIO = 2'd2;
    localparam logic [ST_W-1:0] ST_EMPTY   = 2'd3;

    // operation broadcast to every cell
    typedef struct packed {
        logic             enq;
        logic             deq;
        logic [VAL_W-1:0] value;
        logic [PRI_W-1:0] pri;
    } t_cell_op;

endpackage

/* hw/rtl/spq_if.sv */
// spq_if: valid/ready channels for request and result words
// depends on spq_pkg for field widths
interface spq_in_if;
    import spq_pkg::*;
    logic                    valid;
    logic                    ready;
    logic                    command;
    logic signed [VAL_W-1:0] value;
    logic signed [REQ_W-1:0] priority_req;

    modport source (output valid, command, value, priority_req, input ready);
    modport sink   (input valid, command, value, priority_req, output ready);
endinterface

interface spq_out_if;
    import spq_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [ST_W-1:0]         status;
    logic signed [VAL_W-1:0] removed_value;
    logic [PRI_W-1:0]        removed_priority;
    logic [COUNT_W-1:0]      occupancy;

    modport source (output valid, status, removed_value, removed_priority, occupancy,
                    input ready);
    modport sink   (input valid, status, removed_value, removed_priority, occupancy,
                    output ready);
endinterface

/* hw/rtl/spq_cell.sv */
// spq_cell: one slot of the sorted row, holding a value and its priority
// depends on spq_pkg for widths and the operation word
module spq_cell
    import spq_pkg::*;
(
    input  logic             i_clk,
    input  t_cell_op         i_op,
    input  logic             i_occ,
    input  logic             i_left_behind,
    input  logic [VAL_W-1:0] i_left_value,
    input  logic [PRI_W-1:0] i_left_pri,
    input  logic [VAL_W-1:0] i_right_value,
    input  logic [PRI_W-1:0] i_right_pri,
    output logic             o_behind,
    output logic [VAL_W-1:0] o_value,
    output logic [PRI_W-1:0] o_pri
);

    logic [VAL_W-1:0] r_value, n_value;
    logic [PRI_W-1:0] r_pri, n_pri;

    // new word goes behind this slot when it holds equal or higher priority
    assign o_behind = i_occ && (r_pri >= i_op.pri);

    // keep, take the new word, shift from the left or shift from the right
    always_comb begin
        n_value = r_value;
        n_pri   = r_pri;
        if (i_op.enq && !o_behind) begin
            if (i_left_behind) begin
                n_value = i_op.value;
                n_pri   = i_op.pri;
            end else begin
                n_value = i_left_value;
                n_pri   = i_left_pri;
            end
        end else if (i_op.deq) begin
            n_value = i_right_value;
            n_pri   = i_right_pri;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_pri   <= n_pri;
    end

    assign o_value = r_value;
    assign o_pri   = r_pri;

endmodule

/* hw/rtl/sorted_priority_queue.sv */
// sorted_priority_queue: top level, a row of spq_cell slots with count and result register
// depends on spq_pkg, spq_if and spq_cell
//
// Bounded priority queue of DEPTH entries kept in descending priority order, equal
// priorities in arrival order. Every slot compares and shifts in the same cycle, so
// the block takes one operation (enqueue or dequeue) every clock cycle unless the
// result is stalled; the result word appears in the output register on the cycle after
// the operation is taken. The request side stays ready while the output register is
// empty or being read, so a stalled result holds off only the next request. An enqueue
// with a negative priority or into a full queue is refused with a status code and changes nothing.
module sorted_priority_queue
    import spq_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    spq_in_if.sink       i_in,
    spq_out_if.source    o_out
);

    logic [COUNT_W-1:0] r_count, n_count;
    logic               r_out_valid;
    logic [ST_W-1:0]    r_status, n_status;
    logic [VAL_W-1:0]   r_rm_value, n_rm_value;
    logic [PRI_W-1:0]   r_rm_pri, n_rm_pri;

    logic               w_take;
    logic               w_full, w_empty;
    t_cell_op           w_op;

    logic [DEPTH-1:0]   w_behind;
    logic [VAL_W-1:0]   w_value [DEPTH];
    logic [PRI_W-1:0]   w_pri   [DEPTH];

    // request taken whenever the result register is free or draining
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_take     = i_in.valid && i_in.ready;

    assign w_full  = (r_count == COUNT_W'(DEPTH));
    assign w_empty = (r_count == '0);

    // decode the request into a status and a cell operation
    always_comb begin
        w_op.enq   = 1'b0;
        w_op.deq   = 1'b0;
        w_op.value = i_in.value;
        w_op.pri   = i_in.priority_req[PRI_W-1:0];
        n_status   = ST_OK;
        n_rm_value = '0;
        n_rm_pri   = '0;
        n_count    = r_count;
        if (i_in.command == CMD_ENQ) begin
            if (w_full) begin
                n_status = ST_FULL;
            end else if (i_in.priority_req[REQ_W-1]) begin
                n_status = ST_BADPRIO;
            end else begin
                w_op.enq = w_take;
                n_count  = r_count + COUNT_W'(1);
            end
        end else begin
            if (w_empty) begin
                n_status = ST_EMPTY;
            end else begin
                w_op.deq   = w_take;
                n_rm_value = w_value[0];
                n_rm_pri   = w_pri[0];
                n_count    = r_count - COUNT_W'(1);
            end
        end
    end

    // row of slots, each linked to both neighbours
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic             w_left_behind;
        logic [VAL_W-1:0] w_left_value, w_right_value;
        logic [PRI_W-1:0] w_left_pri, w_right_pri;

        if (g == 0) begin : g_head
            assign w_left_behind = 1'b1;
            assign w_left_value  = i_in.value;
            assign w_left_pri    = w_op.pri;
        end else begin : g_body
            assign w_left_behind = w_behind[g-1];
            assign w_left_value  = w_value[g-1];
            assign w_left_pri    = w_pri[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_right_value = w_value[g];
            assign w_right_pri   = w_pri[g];
        end else begin : g_inner
            assign w_right_value = w_value[g+1];
            assign w_right_pri   = w_pri[g+1];
        end

        spq_cell u_cell (
            .i_clk         (i_clk),
            .i_op          (w_op),
            .i_occ         (COUNT_W'(g) < r_count),
            .i_left_behind (w_left_behind),
            .i_left_value  (w_left_value),
            .i_left_pri    (w_left_pri),
            .i_right_value (w_right_value),
            .i_right_pri   (w_right_pri),
            .o_behind      (w_behind[g]),
            .o_value       (w_value[g]),
            .o_pri         (w_pri[g])
        );
    end

    // entry count and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_count <= n_count;
            end
            if (w_take) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_status   <= n_status;
            r_rm_value <= n_rm_value;
            r_rm_pri   <= n_rm_pri;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.status           = r_status;
    assign o_out.removed_value    = r_rm_value;
    assign o_out.removed_priority = r_rm_pri;
    assign o_out.occupancy        = r_count;

endmodule

/* hw/rtl/spq_checker.sv */
// spq_port_checks: port-level checks on the result channel of sorted_priority_queue
// depends on spq_pkg; bound to the top level below
module spq_port_checks
    import spq_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [ST_W-1:0]    i_status,
    input logic [VAL_W-1:0]   i_removed_value,
    input logic [PRI_W-1:0]   i_removed_priority,
    input logic [COUNT_W-1:0] i_occupancy
);

    // stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status)
            && $stable(i_removed_value) && $stable(i_removed_priority)
            && $stable(i_occupancy))
        else $error("result word changed while stalled");

    // occupancy never exceeds the depth
    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_occupancy <= COUNT_W'(DEPTH))
        else $error("occupancy beyond depth");

    // empty report shows an empty queue and no removed word
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ST_EMPTY |->
            i_occupancy == '0 && i_removed_value == '0 && i_removed_priority == '0)
        else $error("inconsistent empty report");

    // full report only with the queue at depth, nothing removed
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ST_FULL |->
            i_occupancy == COUNT_W'(DEPTH) && i_removed_value == '0
            && i_removed_priority == '0)
        else $error("inconsistent full report");

endmodule

bind sorted_priority_queue spq_port_checks u_spq_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_out_valid        (o_out.valid),
    .i_out_ready        (o_out.ready),
    .i_status           (o_out.status),
    .i_removed_value    (o_out.removed_value),
    .i_removed_priority (o_out.removed_priority),
    .i_occupancy        (o_out.occupancy)
);
